>>> src/b64sd_pkg.sv
// shared types and constants for the base64 stream decoder
package b64sd_pkg;

	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [5:0] OFFSET_LC    = 6'd26;
	localparam logic [5:0] OFFSET_DIGIT = 6'd52;

	localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		PHASE_FIRST  = 2'd0,
		PHASE_SECOND = 2'd1,
		PHASE_THIRD  = 2'd2,
		PHASE_FOURTH = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_end;
		logic [15:0] total_bytes;
	} out_item_t;

	typedef struct packed {
		logic       is_sextet;
		logic       is_break;
		logic [5:0] value;
	} sextet_info_t;

endpackage

>>> src/b64sd_sextet.sv
// character classifier and base64 alphabet lookup
module b64sd_sextet (
	input  logic [7:0]             in_char,
	output b64sd_pkg::sextet_info_t info
);

	logic [5:0] diff;

	always_comb begin
		diff = '0;
		info.is_sextet = 1'b0;
		info.is_break = (in_char == b64sd_pkg::CHAR_LF) || (in_char == b64sd_pkg::CHAR_CR);
		info.value = '0;
		if (in_char >= b64sd_pkg::CHAR_UC_A && in_char <= b64sd_pkg::CHAR_UC_Z) begin
			diff = 6'(in_char - b64sd_pkg::CHAR_UC_A);
			info.is_sextet = 1'b1;
			info.value = diff;
		end else if (in_char >= b64sd_pkg::CHAR_LC_A && in_char <= b64sd_pkg::CHAR_LC_Z) begin
			diff = 6'(in_char - b64sd_pkg::CHAR_LC_A);
			info.is_sextet = 1'b1;
			info.value = diff + b64sd_pkg::OFFSET_LC;
		end else if (in_char >= b64sd_pkg::CHAR_ZERO && in_char <= b64sd_pkg::CHAR_NINE) begin
			diff = 6'(in_char - b64sd_pkg::CHAR_ZERO);
			info.is_sextet = 1'b1;
			info.value = diff + b64sd_pkg::OFFSET_DIGIT;
		end else if (in_char == b64sd_pkg::CHAR_PLUS) begin
			info.is_sextet = 1'b1;
			info.value = b64sd_pkg::SEXTET_PLUS;
		end else if (in_char == b64sd_pkg::CHAR_SLASH) begin
			info.is_sextet = 1'b1;
			info.value = b64sd_pkg::SEXTET_SLASH;
		end
	end

endmodule

>>> src/b64sd_core.sv
// group phase, stored sextet, byte count and byte assembly
module b64sd_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic                    item_end,
	input  b64sd_pkg::sextet_info_t info,
	output logic                    res_valid,
	output b64sd_pkg::out_item_t    res
);

	b64sd_pkg::phase_t phase_q, phase_d;
	logic [5:0]  prev_q, prev_d;
	logic [15:0] total_q, total_d;
	logic [15:0] total_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64sd_pkg::PHASE_FIRST;
			prev_q <= '0;
			total_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			prev_q <= prev_d;
			total_q <= total_d;
		end
	end

	assign total_inc = (total_q == b64sd_pkg::TOTAL_MAX) ? total_q : total_q + 16'd1;

	always_comb begin
		phase_d = phase_q;
		prev_d = prev_q;
		total_d = total_q;
		res_valid = 1'b0;
		res.out_byte = '0;
		res.out_end = 1'b0;
		res.total_bytes = total_q;
		if (item_end) begin
			res_valid = 1'b1;
			res.out_end = 1'b1;
			phase_d = b64sd_pkg::PHASE_FIRST;
			prev_d = '0;
			total_d = '0;
		end else if (info.is_break) begin
			phase_d = b64sd_pkg::PHASE_FIRST;
			prev_d = '0;
		end else if (info.is_sextet) begin
			prev_d = info.value;
			case (phase_q)
				b64sd_pkg::PHASE_FIRST: begin
					phase_d = b64sd_pkg::PHASE_SECOND;
				end
				b64sd_pkg::PHASE_SECOND: begin
					phase_d = b64sd_pkg::PHASE_THIRD;
					res_valid = 1'b1;
					res.out_byte = {prev_q, info.value[5:4]};
				end
				b64sd_pkg::PHASE_THIRD: begin
					phase_d = b64sd_pkg::PHASE_FOURTH;
					res_valid = 1'b1;
					res.out_byte = {prev_q[3:0], info.value[5:2]};
				end
				default: begin
					phase_d = b64sd_pkg::PHASE_FIRST;
					res_valid = 1'b1;
					res.out_byte = {prev_q[1:0], info.value};
				end
			endcase
			if (res_valid) begin
				total_d = total_inc;
				res.total_bytes = total_inc;
			end
		end
	end

endmodule

>>> src/base64_stream_decoder_top.sv
// base64 stream decoder top level: input register, decode, result register
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------
//  in       | sink      | in_valid / in_ready   | in_data   (in_char, in_end)
//  out      | source    | out_valid / out_ready | out_data  (out_byte, out_end, total_bytes)
//
// one item per cycle while out is not stalled; a result is registered when its item leaves the input register
// decode and state update sit between the input register and the result register
// a character that gives no result is dropped in the decode stage
// a stall on out holds the result register and backs up through the input register
// reset clears the valid flags of both stages and all decode state
module base64_stream_decoder_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  b64sd_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output b64sd_pkg::out_item_t out_data
);

	logic                    valid_s1;
	b64sd_pkg::in_item_t     item_s1;
	logic                    advance;
	logic                    take;
	b64sd_pkg::sextet_info_t info;
	logic                    res_valid;
	b64sd_pkg::out_item_t    res;
	logic                    valid_s2;
	b64sd_pkg::out_item_t    item_s2;

	assign advance = !valid_s2 || out_ready;
	assign take = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	b64sd_sextet u_sextet (
		.in_char (item_s1.in_char),
		.info    (info)
	);

	b64sd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item_end  (item_s1.in_end),
		.info      (info),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			item_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = item_s2;

endmodule

>>> src/b64sd_checker.sv
// port-level checks for the base64 stream decoder, bound to the top level
module b64sd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input b64sd_pkg::out_item_t out_data
);

	logic out_acc;
	assign out_acc = out_valid && out_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_end_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_end |-> out_data.out_byte == 8'd0)
		else $error("end item carries a nonzero byte");

	a_byte_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.out_end |-> out_data.total_bytes != 16'd0)
		else $error("byte item with zero total");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !out_data.out_end) ##1 (out_acc && !out_data.out_end) |->
		(out_data.total_bytes == $past(out_data.total_bytes) + 16'd1) ||
		(out_data.total_bytes == b64sd_pkg::TOTAL_MAX &&
		 $past(out_data.total_bytes) == b64sd_pkg::TOTAL_MAX))
		else $error("byte count did not step by one");

endmodule

bind base64_stream_decoder_top b64sd_checker u_b64sd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
